// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define TMA_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define TMA_ASSERT(label, prop, msg) `TMA_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== hw/rtl/tma_pkg.sv =====
package tma_pkg;

   localparam int WINDOW_DEPTH = 8;

   localparam int RAW_W   = 14;
   localparam int VALUE_W = 15;
   localparam int AVG_W   = 15;
   localparam int SAMP_W  = 4;

   localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int TOTAL_W = VALUE_W + $clog2(WINDOW_DEPTH);
   localparam int CNT_RAW_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CNT_W   = (CNT_RAW_W > SAMP_W) ? CNT_RAW_W : SAMP_W;
   localparam int ITER_W  = $clog2(TOTAL_W + 1);

   localparam int REQ_TDATA_W = ((RAW_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = AVG_W + SAMP_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic signed [VALUE_W-1:0] RAW_OFFSET = VALUE_W'(3960);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

endpackage

// ===== hw/rtl/temperature_moving_average.sv =====
// Moving average of temperature readings. Each req transfer carries one raw 14-bit converter
// code; it is turned into hundredths of a degree C (raw - 3960), written into an
// eight-entry ring, and one rsp transfer returns the mean of the stored readings together
// with how many readings it covers (the count grows from 1 until the ring wraps, then stays
// at the window size). The mean is truncated toward zero. Each item runs through these steps
// in order: update the running total from the ring slot being replaced, run the bit-serial
// divider that handles the warm-up counts at one quotient bit per cycle, see the divider
// finish, load the output register and make the rsp transfer. req_tready is low while an item
// is in work; the result sits in an output register so a stalled consumer only holds the
// block once the next result is ready.
module temperature_moving_average (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // raw_reading [13:0], zero [15:14]
   input  logic [tma_pkg::REQ_TDATA_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // average_centideg [14:0], samples_averaged [18:15], zero [23:19]
   output logic [tma_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   localparam int TW = tma_pkg::TOTAL_W;

   tma_pkg::state_type                   state_ff, state_in;
   logic [tma_pkg::SLOT_W-1:0]           slot_ff, slot_in;
   logic                                 filled_ff, filled_in;
   logic signed [TW-1:0]                 total_ff, total_in;
   logic signed [tma_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [tma_pkg::CNT_W-1:0]            count_ff, count_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [tma_pkg::AVG_W-1:0]     rsp_avg_ff, rsp_avg_in;
   logic [tma_pkg::SAMP_W-1:0]           rsp_cnt_ff, rsp_cnt_in;

   logic                                 req_xfer;
   logic                                 ring_wr;
   logic signed [tma_pkg::VALUE_W-1:0]   old_value;
   logic                                 div_start;
   logic                                 div_done;
   logic signed [TW-1:0]                 div_quotient;
   logic [tma_pkg::SLOT_W-1:0]           slot_next;

   assign req_tready = (state_ff == tma_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   tma_ring u_ring (
      .clock    (clock),
      .wr_en    (ring_wr),
      .wr_slot  (slot_ff),
      .wr_value (value_ff),
      .rd_en    (req_xfer),
      .rd_slot  (slot_ff),
      .rd_value (old_value)
   );

   tma_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tma_pkg::ST_IDLE;
         slot_ff      <= '0;
         filled_ff    <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      count_ff   <= count_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign slot_next = (slot_ff == tma_pkg::SLOT_W'(tma_pkg::WINDOW_DEPTH - 1))
                      ? '0 : slot_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      filled_in    = filled_ff;
      total_in     = total_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ring_wr      = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         tma_pkg::ST_IDLE: begin
            if (req_xfer) begin
               value_in = $signed({1'b0, req_tdata[tma_pkg::RAW_W-1:0]}) - tma_pkg::RAW_OFFSET;
               state_in = tma_pkg::ST_READ;
            end
         end
         tma_pkg::ST_READ: begin
            ring_wr   = 1'b1;
            total_in  = total_ff + TW'(value_ff)
                        - (filled_ff ? TW'(old_value) : TW'(0));
            slot_in   = slot_next;
            filled_in = filled_ff || (slot_next == '0);
            count_in  = filled_in ? tma_pkg::CNT_W'(tma_pkg::WINDOW_DEPTH)
                                  : tma_pkg::CNT_W'(slot_next);
            div_start = 1'b1;
            state_in  = tma_pkg::ST_DIVIDE;
         end
         tma_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = tma_pkg::ST_OUTPUT;
            end
         end
         tma_pkg::ST_OUTPUT: begin
            // quotient holds until the next start, so wait here for a free output register
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_avg_in   = div_quotient[tma_pkg::AVG_W-1:0];
               rsp_cnt_in   = count_ff[tma_pkg::SAMP_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = tma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tma_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(tma_pkg::RSP_TDATA_W - tma_pkg::RSP_FIELD_W)'(0), rsp_cnt_ff,
                        rsp_avg_ff};

endmodule

// ===== hw/rtl/tma_ring.sv =====
module tma_ring (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [tma_pkg::SLOT_W-1:0]          wr_slot,
   input  logic signed [tma_pkg::VALUE_W-1:0]  wr_value,
   input  logic                                rd_en,
   input  logic [tma_pkg::SLOT_W-1:0]          rd_slot,
   output logic signed [tma_pkg::VALUE_W-1:0]  rd_value
);

   logic signed [tma_pkg::VALUE_W-1:0] mem [tma_pkg::WINDOW_DEPTH];
   logic signed [tma_pkg::VALUE_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value_ff <= mem[rd_slot];
      end
   end

   assign rd_value = rd_value_ff;

endmodule

// ===== hw/rtl/tma_divider.sv =====
module tma_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tma_pkg::TOTAL_W-1:0]  dividend,
   input  logic [tma_pkg::CNT_W-1:0]           divisor,
   output logic                                done,
   output logic signed [tma_pkg::TOTAL_W-1:0]  quotient
);

   localparam int W = tma_pkg::TOTAL_W;
   localparam int C = tma_pkg::CNT_W;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tma_pkg::ITER_W-1:0]    iter_ff, iter_in;
   logic [W-1:0]                  quo_ff, quo_in;
   logic [C-1:0]                  rem_ff, rem_in;
   logic [C-1:0]                  div_ff, div_in;
   logic                          neg_ff, neg_in;
   logic [C:0]                    shifted;
   logic                          fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[W-1]};
      fits    = (shifted >= {1'b0, div_ff});
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         neg_in  = dividend[W-1];
         quo_in  = dividend[W-1] ? W'(-dividend) : W'(dividend);
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         rem_in  = fits ? C'(shifted - {1'b0, div_ff}) : shifted[C-1:0];
         quo_in  = {quo_ff[W-2:0], fits};
         iter_in = iter_ff + 1'b1;
         if (iter_ff == tma_pkg::ITER_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ===== hw/rtl/tma_checker.sv =====
`include "assert_macros.svh"

module tma_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tma_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic                                                      req_xfer;
   logic                                                      rsp_stall;
   logic [tma_pkg::RSP_TDATA_W-tma_pkg::RSP_FIELD_W-1:0]      rsp_pad;

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_pad   = rsp_tdata[tma_pkg::RSP_TDATA_W-1:tma_pkg::RSP_FIELD_W];

   // ready drops after a transfer
   `TMA_ASSERT(a_busy_after_req, req_xfer |=> !req_tready, "ready did not drop after transfer")

   // a result never shows up the cycle right after a transfer
   `TMA_ASSERT(a_no_early_rsp, req_xfer |=> !$rose(rsp_tvalid), "result too early")

   // stalled result holds
   `TMA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "result changed")

   // padding bits stay zero
   `TMA_ASSERT(a_rsp_pad, rsp_tvalid |-> rsp_pad == '0, "padding not zero")

endmodule

bind temperature_moving_average tma_checker u_checker (.*);
